// ----- rtl/nearest_neighbor_image_scaler_defines.svh -----
// ----------------------------------------------------------------------------
// Nearest neighbour image scaler: assertion macros
// Shared assertion wrappers; they compile to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_DEFINES_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_DEFINES_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define NNIS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nnis: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define NNIS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("nnis: next-cycle check failed");
`else
`define NNIS_ASSERT_SAME(label, ante, cons)
`define NNIS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/nnis_pkg.sv -----
// ----------------------------------------------------------------------------
// Nearest neighbour image scaler package
// Field widths, register indices, controller states and the command and
// status groups shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package nnis_pkg;

   // Field and register widths.
   localparam int CSR_W     = 9;
   localparam int CSR_IDX_W = 2;
   localparam int PIX_W     = 8;

   // Arithmetic widths of the coordinate mapping.
   localparam int PROD_W = 2 * CSR_W;
   localparam int NUM_W  = PROD_W + 2;
   localparam int DEN_W  = CSR_W + 1;
   localparam int QUO_W  = CSR_W + 1;

   localparam logic [CSR_W-1:0] DIM_RESET  = 9'd256;
   localparam logic [PIX_W-1:0] FILL_PIXEL = 8'hFF;

   // Configuration register indices.
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT = 2'd3;

   // Operand selection of the shared multiplier.
   typedef enum logic [1:0] {
      MUL_CAP,
      MUL_ROW,
      MUL_COL,
      MUL_ADDR
   } mul_sel_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD_MUL,
      ST_LOAD_WR,
      ST_ROW_MUL,
      ST_ROW_DIV_GO,
      ST_ROW_DIV,
      ST_COL_MUL,
      ST_COL_DIV_GO,
      ST_COL_DIV,
      ST_ADDR_MUL,
      ST_ADDR_SUM,
      ST_READ,
      ST_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        req_ready;
      logic        take;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        div_start;
      logic        div_col;
      logic        save_i1;
      logic        save_j1;
      logic        addr_sum;
      logic        ram_read;
      logic        load_write;
      logic        push;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_fetch;
      logic div_busy;
      logic out_free;
   } status_type;

endpackage

// ----- rtl/nnis_req_if.sv -----
// ----------------------------------------------------------------------------
// Request channel interface
// Carries load and fetch items with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface nnis_req_if;
   import nnis_pkg::*;

   logic             valid;
   logic             ready;
   logic             req_type;
   logic [PIX_W-1:0] pixel_in;

   modport source (output valid, output req_type, output pixel_in, input ready);
   modport sink   (input valid, input req_type, input pixel_in, output ready);
endinterface

// ----- rtl/nnis_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Response channel interface
// Carries destination pixels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface nnis_rsp_if;
   import nnis_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_out;
   logic             filled;
   logic             frame_last;

   modport source (output valid, output pixel_out, output filled, output frame_last,
                   input ready);
   modport sink   (input valid, input pixel_out, input filled, input frame_last,
                   output ready);
endinterface

// ----- rtl/nnis_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nnis_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/nnis_div.sv -----
// ----------------------------------------------------------------------------
// Iterative restoring divider
// Produces one quotient bit per cycle; the quotient is known to fit QUO_W bits.
// ----------------------------------------------------------------------------
module nnis_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [nnis_pkg::NUM_W-1:0] num,
   input  logic [nnis_pkg::DEN_W-1:0] den,
   output logic                       busy,
   output logic [nnis_pkg::QUO_W-1:0] quotient
);
   import nnis_pkg::*;

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [DEN_W-1:0] rem_ff;
   logic [QUO_W-1:0] quo_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   // Trial subtraction of one step.
   always_comb begin
      trial = {rem_ff, quo_ff[QUO_W-1]};
      ge    = (trial >= {1'b0, den_ff});
      diff  = trial - {1'b0, den_ff};
   end

   // Step control.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(QUO_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Partial remainder and quotient shift register.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num[NUM_W-1:QUO_W];
         quo_ff <= num[QUO_W-1:0];
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_ff <= {quo_ff[QUO_W-2:0], ge};
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule

// ----- rtl/nnis_datapath.sv -----
// ----------------------------------------------------------------------------
// Scaler datapath
// Configuration registers, frame store, output position, shared multiplier,
// divider and the output register.
// ----------------------------------------------------------------------------
module nnis_datapath #(
   parameter int MAX_DIM     = 256,
   parameter int STORE_DEPTH = 65536
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [nnis_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [nnis_pkg::CSR_W-1:0]     csr_wr_data,
   input  logic                           req_type,
   input  logic [nnis_pkg::PIX_W-1:0]     pixel_in,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [nnis_pkg::PIX_W-1:0]     pixel_out,
   output logic                           filled,
   output logic                           frame_last,
   input  nnis_pkg::cmd_type              cmd,
   output nnis_pkg::status_type           status
);
   import nnis_pkg::*;

   localparam int AW    = $clog2(STORE_DEPTH);
   localparam int CNT_W = $clog2(STORE_DEPTH + 1);

   logic [CSR_W-1:0]  src_width_ff, src_height_ff, dst_width_ff, dst_height_ff;
   logic [CSR_W-1:0]  sw, sh, dw, dh;
   logic [CSR_W-1:0]  pos_row_ff, pos_col_ff;
   logic [CSR_W-1:0]  pos_row_in, pos_col_in;
   logic [CSR_W-1:0]  i_ff, c_ff, i_in, c_in;
   logic              last_ff, last_in;
   logic [PIX_W-1:0]  pix_ff;
   logic [CNT_W-1:0]  load_cnt_ff;
   logic              load_ok;
   logic [CSR_W-1:0]  mul_a, mul_b, row_ofs;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [NUM_W-1:0]  div_num;
   logic [DEN_W-1:0]  div_den;
   logic [CSR_W-1:0]  div_dim;
   logic              div_busy;
   logic [QUO_W-1:0]  div_quo;
   logic [QUO_W-1:0]  i1_ff, j1_ff;
   logic [PROD_W-1:0] addr_ff;
   logic              inside_ff, hit_ff;
   logic [PIX_W-1:0]  ram_rd_data;
   logic              rsp_valid_ff;
   logic [PIX_W-1:0]  pixel_out_ff;
   logic              filled_ff, frame_last_ff;

   // A dimension of zero acts as one, one above the limit as the limit.
   function automatic logic [CSR_W-1:0] clamp_dim(input logic [CSR_W-1:0] v);
      logic [CSR_W-1:0] r;
      if (v == '0) begin
         r = CSR_W'(1);
      end else if (32'(v) > MAX_DIM) begin
         r = CSR_W'(MAX_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= DIM_RESET;
         src_height_ff <= DIM_RESET;
         dst_width_ff  <= DIM_RESET;
         dst_height_ff <= DIM_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SRC_WIDTH:  src_width_ff  <= csr_wr_data;
            CSR_SRC_HEIGHT: src_height_ff <= csr_wr_data;
            CSR_DST_WIDTH:  dst_width_ff  <= csr_wr_data;
            CSR_DST_HEIGHT: dst_height_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign sw = clamp_dim(src_width_ff);
   assign sh = clamp_dim(src_height_ff);
   assign dw = clamp_dim(dst_width_ff);
   assign dh = clamp_dim(dst_height_ff);

   // Position of the next fetch, clamped to the frame, and its successor.
   always_comb begin
      logic [CSR_W-1:0] dhm1, dwm1, r, c;
      logic             row_end, col_end;
      dhm1    = dh - CSR_W'(1);
      dwm1    = dw - CSR_W'(1);
      r       = (pos_row_ff > dhm1) ? dhm1 : pos_row_ff;
      c       = (pos_col_ff > dwm1) ? dwm1 : pos_col_ff;
      row_end = (r == dhm1);
      col_end = (c == dwm1);
      i_in    = dhm1 - r;
      c_in    = c;
      last_in = row_end && col_end;
      if (col_end) begin
         pos_col_in = '0;
         pos_row_in = row_end ? '0 : r + CSR_W'(1);
      end else begin
         pos_col_in = c + CSR_W'(1);
         pos_row_in = r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_row_ff <= '0;
         pos_col_ff <= '0;
      end else if (cmd.take && req_type) begin
         pos_row_ff <= pos_row_in;
         pos_col_ff <= pos_col_in;
      end
   end

   // Item capture.
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         pix_ff  <= pixel_in;
         i_ff    <= i_in;
         c_ff    <= c_in;
         last_ff <= last_in;
      end
   end

   // Shared multiplier with registered product.
   assign row_ofs = sh - CSR_W'(1) - i1_ff[CSR_W-1:0];

   always_comb begin
      case (cmd.mul_sel)
         MUL_CAP: begin
            mul_a = sw;
            mul_b = sh;
         end
         MUL_ROW: begin
            mul_a = i_ff;
            mul_b = sh;
         end
         MUL_COL: begin
            mul_a = c_ff;
            mul_b = sw;
         end
         MUL_ADDR: begin
            mul_a = sw;
            mul_b = row_ofs;
         end
         default: begin
            mul_a = sw;
            mul_b = sh;
         end
      endcase
      prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // Rounded mapping: floor((2*pos*src + dst) / (2*dst)).
   assign div_dim = cmd.div_col ? dw : dh;
   assign div_num = {1'b0, prod_ff, 1'b0} + NUM_W'(div_dim);
   assign div_den = {div_dim, 1'b0};

   nnis_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .num      (div_num),
      .den      (div_den),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // Mapped coordinates, store address and edge checks.
   always_ff @(posedge clock) begin
      if (cmd.save_i1) begin
         i1_ff <= div_quo;
      end
      if (cmd.save_j1) begin
         j1_ff <= div_quo;
      end
      if (cmd.addr_sum) begin
         addr_ff   <= prod_ff + PROD_W'(j1_ff);
         inside_ff <= (i1_ff < {1'b0, sh}) && (j1_ff < {1'b0, sw});
      end
      if (cmd.ram_read) begin
         hit_ff <= inside_ff && (32'(addr_ff) < STORE_DEPTH);
      end
   end

   // Load counter; loads at or past capacity are dropped.
   assign load_ok = (32'(load_cnt_ff) < 32'(prod_ff)) && (32'(load_cnt_ff) < STORE_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         load_cnt_ff <= '0;
      end else if (cmd.load_write && load_ok) begin
         load_cnt_ff <= load_cnt_ff + CNT_W'(1);
      end
   end

   // Frame store.
   nnis_ram #(
      .WIDTH (PIX_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.load_write && load_ok),
      .wr_addr (load_cnt_ff[AW-1:0]),
      .wr_data (pix_ff),
      .rd_en   (cmd.ram_read),
      .rd_addr (AW'(addr_ff)),
      .rd_data (ram_rd_data)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         pixel_out_ff  <= hit_ff ? ram_rd_data : FILL_PIXEL;
         filled_ff     <= !hit_ff;
         frame_last_ff <= last_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign pixel_out  = pixel_out_ff;
   assign filled     = filled_ff;
   assign frame_last = frame_last_ff;

   assign status.req_fetch = req_type;
   assign status.div_busy  = div_busy;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
endmodule

// ----- rtl/nnis_ctrl.sv -----
// ----------------------------------------------------------------------------
// Scaler controller
// Sequences each fetch through multiply, divide, address and read steps.
// ----------------------------------------------------------------------------
module nnis_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  nnis_pkg::status_type status,
   output nnis_pkg::cmd_type    cmd
);
   import nnis_pkg::*;

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.mul_sel = MUL_CAP;
      case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = status.req_fetch ? ST_ROW_MUL : ST_LOAD_MUL;
            end
         end
         ST_LOAD_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_CAP;
            state_in    = ST_LOAD_WR;
         end
         ST_LOAD_WR: begin
            cmd.load_write = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_ROW_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ROW;
            state_in    = ST_ROW_DIV_GO;
         end
         ST_ROW_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_ROW_DIV;
         end
         ST_ROW_DIV: begin
            if (!status.div_busy) begin
               state_in = ST_COL_MUL;
            end
         end
         ST_COL_MUL: begin
            cmd.save_i1 = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_COL;
            state_in    = ST_COL_DIV_GO;
         end
         ST_COL_DIV_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_col   = 1'b1;
            state_in      = ST_COL_DIV;
         end
         ST_COL_DIV: begin
            if (!status.div_busy) begin
               state_in = ST_ADDR_MUL;
            end
         end
         ST_ADDR_MUL: begin
            cmd.save_j1 = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ADDR;
            state_in    = ST_ADDR_SUM;
         end
         ST_ADDR_SUM: begin
            cmd.addr_sum = 1'b1;
            state_in     = ST_READ;
         end
         ST_READ: begin
            cmd.ram_read = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

// ----- rtl/nearest_neighbor_image_scaler.sv -----
// ----------------------------------------------------------------------------
// Nearest neighbour image scaler
// Stores an 8-bit grey source frame and emits a scaled destination frame.
// ----------------------------------------------------------------------------
// Items arrive on req_chan: a load item (req_type 0) writes pixel_in to the
// next place of the frame store, a fetch item (req_type 1) produces the next
// destination pixel on rsp_chan, in stored (bottom-up) raster order, with
// frame_last on the final pixel of each destination frame.
// The user writes the four dimension registers through csr_wr_en, csr_index and
// csr_wr_data only while the block is idle; the block itself leaves this unchecked.
// A load item passes through a multiply and a write state before the next item
// is accepted. The item after a fetch is accepted once the fetch's result is
// in the output register; two 10-step divisions for the row and column
// mapping in the shared divider are the longest part of a fetch.
// The result waits in an output register, so a new item is accepted while
// the receiver stalls; a fetch that finishes with the register still full
// holds until the register is taken.
// Reset clears the load counter, the output position and the handshake state
// and restores all dimensions to 256; the frame store holds no reset value
// and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "nearest_neighbor_image_scaler_defines.svh"

module nearest_neighbor_image_scaler #(
   parameter int MAX_DIM     = 256,
   parameter int STORE_DEPTH = 65536
) (
   input  logic                           clock,
   input  logic                           reset,
   nnis_req_if.sink                       req_chan,
   nnis_rsp_if.source                     rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [nnis_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [nnis_pkg::CSR_W-1:0]     csr_wr_data
);
   import nnis_pkg::*;

   cmd_type    ctrl_cmd;
   status_type ctrl_status;

   // Controller.
   nnis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .status    (ctrl_status),
      .cmd       (ctrl_cmd)
   );

   assign req_chan.ready = ctrl_cmd.req_ready;

   // Datapath.
   nnis_datapath #(
      .MAX_DIM     (MAX_DIM),
      .STORE_DEPTH (STORE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_type    (req_chan.req_type),
      .pixel_in    (req_chan.pixel_in),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .pixel_out   (rsp_chan.pixel_out),
      .filled      (rsp_chan.filled),
      .frame_last  (rsp_chan.frame_last),
      .cmd         (ctrl_cmd),
      .status      (ctrl_status)
   );

   // A result is written only into a free output register.
   `NNIS_ASSERT_SAME(a_push_free, ctrl_cmd.push, ctrl_status.out_free)
   // A written result is offered in the following cycle.
   `NNIS_ASSERT_NEXT(a_push_shown, ctrl_cmd.push, rsp_chan.valid)
   // The divider is never restarted mid-division, nor busy while items are taken.
   `NNIS_ASSERT_SAME(a_div_idle, ctrl_cmd.div_start || req_chan.ready, !ctrl_status.div_busy)
endmodule

// ----- tb/scaler_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// Scaler testbench package
// Item kind codes shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package scaler_tb_pkg;

   // Kind of a request item.
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_FETCH = 1'b1;

endpackage

// ----- tb/scaler_checker.sv -----
// ----------------------------------------------------------------------------
// Scaler checker
// Watches the request, response and register ports, keeps its own frame
// store and destination position, predicts every destination pixel and
// compares each response item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module scaler_checker (
   input  logic                           clock,
   input  logic                           reset,
   nnis_req_if                            req_mon,
   nnis_rsp_if                            rsp_mon,
   input  logic                           csr_wr_en,
   input  logic [nnis_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [nnis_pkg::CSR_W-1:0]     csr_wr_data,
   output int                             fail_count,
   output int                             pending
);
   import nnis_pkg::*;
   import scaler_tb_pkg::*;

   localparam int unsigned LARGEST_DIM = 256;
   localparam int unsigned STORE_SIZE  = 65536;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             filled;
      logic             frame_last;
   } scaled_pixel_type;

   logic [PIX_W-1:0] frame_store [STORE_SIZE];
   logic [CSR_W-1:0] dims [4];
   int unsigned      load_total;
   int unsigned      row_pos;
   int unsigned      col_pos;
   scaled_pixel_type expected_pixels [$];

   // A dimension of zero behaves as one, and one above the largest as the largest.
   function automatic int unsigned dim_value(input logic [CSR_W-1:0] v);
      if (v == '0)
         return 1;
      if (v > LARGEST_DIM)
         return LARGEST_DIM;
      return 32'(v);
   endfunction

   // Rounded mapping of a destination coordinate onto the source.
   function automatic int unsigned map_coord(input int unsigned pos, input int unsigned src,
                                             input int unsigned dst);
      return (2 * pos * src + dst) / (2 * dst);
   endfunction

   // Store a source pixel unless the frame store is already full for this size.
   function automatic void store_pixel(input logic [PIX_W-1:0] pix);
      int unsigned cap;
      cap = dim_value(dims[CSR_SRC_WIDTH]) * dim_value(dims[CSR_SRC_HEIGHT]);
      if (cap > STORE_SIZE)
         cap = STORE_SIZE;
      if (load_total < cap) begin
         frame_store[load_total] = pix;
         load_total++;
      end
   endfunction

   // Work out the next destination pixel and advance the output position.
   function automatic scaled_pixel_type scale_next();
      int unsigned      sw, sh, dw, dh, r, c, i1, j1, addr;
      logic             row_end, col_end;
      scaled_pixel_type res;
      sw = dim_value(dims[CSR_SRC_WIDTH]);
      sh = dim_value(dims[CSR_SRC_HEIGHT]);
      dw = dim_value(dims[CSR_DST_WIDTH]);
      dh = dim_value(dims[CSR_DST_HEIGHT]);
      r  = row_pos;
      c  = col_pos;
      // A position left beyond a shrunken frame counts as its last row or column.
      if (r > dh - 1)
         r = dh - 1;
      if (c > dw - 1)
         c = dw - 1;
      row_end = (r == dh - 1);
      col_end = (c == dw - 1);
      i1 = map_coord(dh - 1 - r, sh, dh);
      j1 = map_coord(c, sw, dw);
      res.pixel  = FILL_PIXEL;
      res.filled = 1'b1;
      if (i1 < sh && j1 < sw) begin
         addr = sw * (sh - 1 - i1) + j1;
         if (addr < STORE_SIZE) begin
            res.pixel  = frame_store[addr];
            res.filled = 1'b0;
         end
      end
      res.frame_last = row_end && col_end;
      if (col_end) begin
         col_pos = 0;
         row_pos = row_end ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
      return res;
   endfunction

   // Compare one response item with the oldest prediction.
   function automatic void check_pixel();
      scaled_pixel_type want;
      if (expected_pixels.size() == 0) begin
         $display("%0t: unexpected item: pixel_out %0d filled %b frame_last %b", $time,
                  rsp_mon.pixel_out, rsp_mon.filled, rsp_mon.frame_last);
         fail_count++;
         return;
      end
      want = expected_pixels.pop_front();
      if (rsp_mon.pixel_out !== want.pixel) begin
         $display("%0t: pixel_out mismatch: expected %0d, actual %0d", $time,
                  want.pixel, rsp_mon.pixel_out);
         fail_count++;
      end
      if (rsp_mon.filled !== want.filled) begin
         $display("%0t: filled mismatch: expected %b, actual %b", $time,
                  want.filled, rsp_mon.filled);
         fail_count++;
      end
      if (rsp_mon.frame_last !== want.frame_last) begin
         $display("%0t: frame_last mismatch: expected %b, actual %b", $time,
                  want.frame_last, rsp_mon.frame_last);
         fail_count++;
      end
   endfunction

   // Sample every port at the clock edge, as the block does.
   always @(posedge clock) begin
      if (reset) begin
         load_total = 0;
         row_pos    = 0;
         col_pos    = 0;
         dims[CSR_SRC_WIDTH]  = DIM_RESET;
         dims[CSR_SRC_HEIGHT] = DIM_RESET;
         dims[CSR_DST_WIDTH]  = DIM_RESET;
         dims[CSR_DST_HEIGHT] = DIM_RESET;
         expected_pixels.delete();
      end else begin
         if (csr_wr_en)
            dims[csr_index] = csr_wr_data;
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.req_type == REQ_LOAD)
               store_pixel(req_mon.pixel_in);
            else
               expected_pixels.push_back(scale_next());
         end
         if (rsp_mon.valid && rsp_mon.ready)
            check_pixel();
      end
      pending = expected_pixels.size();
   end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Scaler testbench top
// Drives load and fetch items and register writes into the scaler over a run
// of frame sizes, from the extremes to random ones, with random idling on both
// channels, a long receiver hold-off and a full pause of the sender. The
// checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import nnis_pkg::*;
   import scaler_tb_pkg::*;

   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 1000000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wr_data;
   logic                 hold_request = 1'b0;
   int                   fail_count;
   int                   pending;
   int                   sender_idle_pct = 0;
   int                   receiver_stall_pct = 0;
   int                   cycle_count = 0;
   int unsigned          loaded = 0;
   logic [CSR_W-1:0]     cur_dims [4] = '{DIM_RESET, DIM_RESET, DIM_RESET, DIM_RESET};

   nnis_req_if req_chan ();
   nnis_rsp_if rsp_chan ();

   nearest_neighbor_image_scaler dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   scaler_checker pixel_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   // Clock with a period of 10.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on the length of the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receiver: random stalls, and one long hold-off once it is requested.
   initial begin
      bit hold_done;
      hold_done      = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done      = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   function automatic int unsigned dim_value(input logic [CSR_W-1:0] v);
      if (v == '0)
         return 1;
      if (v > 256)
         return 256;
      return 32'(v);
   endfunction

   // Number of source pixels the current size needs in the frame store.
   function automatic int unsigned frame_area();
      return dim_value(cur_dims[CSR_SRC_WIDTH]) * dim_value(cur_dims[CSR_SRC_HEIGHT]);
   endfunction

   function automatic void set_idling(input int mode);
      case (mode % 4)
         0: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
         1: begin
            sender_idle_pct    = 49;
            receiver_stall_pct = 0;
         end
         2: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 49;
         end
         default: begin
            sender_idle_pct    = 13;
            receiver_stall_pct = 13;
         end
      endcase
   endfunction

   // Offer one item, with random idle cycles first, and wait for acceptance.
   task automatic offer(input logic kind, input logic [PIX_W-1:0] pix);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= kind;
      req_chan.pixel_in <= pix;
      do
         @(posedge clock);
      while (!req_chan.ready);
      if (kind == REQ_LOAD && loaded < frame_area())
         loaded++;
   endtask

   // Stop sending, wait for every expected pixel, then let a load finish too.
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_frame_sizes(input logic [CSR_W-1:0] sw, input logic [CSR_W-1:0] sh,
                                  input logic [CSR_W-1:0] dw, input logic [CSR_W-1:0] dh);
      logic [CSR_IDX_W-1:0] regs [4] = '{CSR_SRC_WIDTH, CSR_SRC_HEIGHT,
                                         CSR_DST_WIDTH, CSR_DST_HEIGHT};
      logic [CSR_W-1:0]     vals [4];
      vals = '{sw, sh, dw, dh};
      for (int k = 0; k < 4; k++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= regs[k];
         csr_wr_data <= vals[k];
         cur_dims[regs[k]] = vals[k];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   // One frame size: fill the store far enough, then mostly fetches with some
   // loads, which are ignored once the store holds the whole source frame.
   task automatic run_phase(input logic [CSR_W-1:0] sw, input logic [CSR_W-1:0] sh,
                            input logic [CSR_W-1:0] dw, input logic [CSR_W-1:0] dh,
                            input int count, input int mode, input bit long_hold,
                            input bit mid_pause);
      settle();
      set_frame_sizes(sw, sh, dw, dh);
      set_idling(mode);
      while (loaded < frame_area())
         offer(REQ_LOAD, PIX_W'($urandom_range(255)));
      for (int k = 0; k < count; k++) begin
         if (long_hold && k == 5)
            hold_request <= 1'b1;
         if (mid_pause && k == count / 2)
            settle();
         if ($urandom_range(99) < 12)
            offer(REQ_LOAD, PIX_W'($urandom_range(255)));
         else
            offer(REQ_FETCH, PIX_W'($urandom_range(255)));
      end
   endtask

   // Stimulus and verdict.
   initial begin
      logic [CSR_W-1:0] sw, sh, dw, dh;
      int               sel;
      csr_wr_en         = 1'b0;
      csr_index         = CSR_SRC_WIDTH;
      csr_wr_data       = '0;
      req_chan.valid    = 1'b0;
      req_chan.req_type = REQ_LOAD;
      req_chan.pixel_in = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // At the reset size the mapping is the identity, so fetches read back loads.
      offer(REQ_LOAD, 8'hFF);
      offer(REQ_LOAD, 8'h00);
      offer(REQ_LOAD, 8'h55);
      offer(REQ_LOAD, 8'hAA);
      offer(REQ_LOAD, 8'h0F);
      offer(REQ_LOAD, 8'hF0);
      repeat (6) offer(REQ_FETCH, PIX_W'($urandom_range(255)));

      // Extreme and out-of-range sizes, with the position left mid-frame.
      run_phase(9'd1, 9'd1, 9'd1, 9'd1, 4, 1, 1'b0, 1'b0);
      run_phase(9'd0, 9'd0, 9'd0, 9'd0, 4, 2, 1'b0, 1'b0);
      run_phase(9'd4, 9'd3, 9'd17, 9'd13, 20, 3, 1'b0, 1'b0);
      run_phase(9'd20, 9'd15, 9'd3, 9'd4, 20, 0, 1'b0, 1'b0);
      run_phase(9'd511, 9'd1, 9'd300, 9'd2, 60, 1, 1'b0, 1'b0);
      run_phase(9'd1, 9'd256, 9'd1, 9'd511, 60, 2, 1'b0, 1'b0);
      run_phase(9'd256, 9'd2, 9'd256, 9'd256, 60, 3, 1'b0, 1'b0);

      // Random sizes, mostly small source frames and short destination frames.
      for (int p = 0; p < 15; p++) begin
         sel = $urandom_range(9);
         if (sel == 0) begin
            sw = CSR_W'($urandom_range(511, 257));
            sh = CSR_W'($urandom_range(2, 0));
         end else if (sel == 1) begin
            sw = CSR_W'($urandom_range(2, 0));
            sh = CSR_W'($urandom_range(511, 257));
         end else begin
            sw = CSR_W'($urandom_range(24, 1));
            sh = CSR_W'($urandom_range(24, 1));
         end
         dw = ($urandom_range(4) == 0) ? CSR_W'($urandom_range(511, 0)) :
                                         CSR_W'($urandom_range(12, 1));
         dh = ($urandom_range(4) == 0) ? CSR_W'($urandom_range(511, 0)) :
                                         CSR_W'($urandom_range(12, 1));
         run_phase(sw, sh, dw, dh, 60, p, p == 4, p == 7);
      end

      settle();
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
